// ===== rtl/core/fepa_pkg.sv =====
// Shared types and constants for the flow event pulse accounting block.
package fepa_pkg;

  typedef enum logic [1:0] {
    CFG_CHECK_INTERVAL = 2'd0,
    CFG_MIN_PULSES     = 2'd1,
    CFG_FLOW_TIMEOUT   = 2'd2,
    CFG_MIN_EVENT      = 2'd3
  } cfg_idx_t;

  localparam logic [15:0] CHECK_INTERVAL_RST = 16'd1000;
  localparam logic [15:0] MIN_PULSES_RST     = 16'd2;
  localparam logic [23:0] FLOW_TIMEOUT_RST   = 24'd10000;
  localparam logic [31:0] MIN_EVENT_RST      = 32'd45;

  localparam logic [15:0] SAT16_MAX = 16'hFFFF;
  localparam logic [23:0] SAT24_MAX = 24'hFF_FFFF;

  typedef struct packed {
    logic [15:0] check_interval_ms;
    logic [15:0] min_pulses_per_interval;
    logic [23:0] flow_timeout_ms;
    logic [31:0] min_event_pulses;
  } cfg_t;

  typedef struct packed {
    logic pulse;
    logic ms_tick;
    logic daily_reset;
    logic hour_tick;
    logic clear_accumulated;
  } in_flags_t;

  typedef struct packed {
    logic flow_active;
    logic led_on;
    logic event_closed;
    logic event_counted;
  } res_flags_t;

endpackage

// ===== rtl/core/fepa_core.sv =====
// Accounting state and the per-request update of counters, timers and totals.
module fepa_core #(
  parameter int COUNT_WIDTH = 32,
  parameter int TOTAL_WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step_en,
  input  fepa_pkg::in_flags_t      step_flags,
  input  fepa_pkg::cfg_t           cfg,
  output fepa_pkg::res_flags_t     res_flags,
  output logic [COUNT_WIDTH-1:0]   cust_cnt,
  output logic [COUNT_WIDTH-1:0]   tech_cnt,
  output logic [TOTAL_WIDTH-1:0]   accum_total,
  output logic [TOTAL_WIDTH-1:0]   daily_total,
  output logic [TOTAL_WIDTH-1:0]   lifetime_total,
  output logic [15:0]              events_cnt,
  output logic [15:0]              hours_cnt
);

  localparam int SUM_WIDTH = ((COUNT_WIDTH > TOTAL_WIDTH) ? COUNT_WIDTH : TOTAL_WIDTH) + 1;
  localparam int CMP_WIDTH = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  logic [COUNT_WIDTH-1:0] cust_r, cust_nxt;
  logic [COUNT_WIDTH-1:0] tech_r, tech_nxt;
  logic [COUNT_WIDTH-1:0] last_chk_r, last_chk_nxt;
  logic [COUNT_WIDTH-1:0] start_r, start_nxt;
  logic                   active_r, active_nxt;
  logic                   led_r, led_nxt;
  logic                   closed_r, closed_nxt;
  logic                   counted_r, counted_nxt;
  logic [15:0]            ival_r, ival_nxt;
  logic [23:0]            idle_r, idle_nxt;
  logic [TOTAL_WIDTH-1:0] accum_r, accum_nxt;
  logic [TOTAL_WIDTH-1:0] daily_r, daily_nxt;
  logic [TOTAL_WIDTH-1:0] life_r, life_nxt;
  logic [15:0]            events_r, events_nxt;
  logic [15:0]            hours_r, hours_nxt;

  logic [COUNT_WIDTH-1:0] cust_inc;
  logic [COUNT_WIDTH-1:0] fresh;
  logic [COUNT_WIDTH-1:0] vol;
  logic [15:0]            ival_inc;
  logic [23:0]            idle_inc;
  logic                   check;
  logic                   flow;
  logic                   vol_big;
  logic [TOTAL_WIDTH-1:0] accum_sum;
  logic [TOTAL_WIDTH-1:0] daily_sum;
  logic [TOTAL_WIDTH-1:0] life_sum;

  function automatic logic [TOTAL_WIDTH-1:0] sat_add(
    input logic [TOTAL_WIDTH-1:0] total,
    input logic [COUNT_WIDTH-1:0] amount
  );
    logic [SUM_WIDTH-1:0] sum;
    sum = SUM_WIDTH'(total) + SUM_WIDTH'(amount);
    if (sum[SUM_WIDTH-1:TOTAL_WIDTH] != '0) begin
      sat_add = '1;
    end else begin
      sat_add = sum[TOTAL_WIDTH-1:0];
    end
  endfunction

  // datapath pieces that do not depend on the branch taken
  assign cust_inc  = step_flags.pulse ? cust_r + COUNT_WIDTH'(1) : cust_r;
  assign ival_inc  = (ival_r < fepa_pkg::SAT16_MAX) ? ival_r + 16'd1 : ival_r;
  assign idle_inc  = (idle_r < fepa_pkg::SAT24_MAX) ? idle_r + 24'd1 : idle_r;
  assign check     = step_flags.ms_tick && (ival_inc >= cfg.check_interval_ms);
  assign fresh     = cust_inc - last_chk_r;
  assign flow      = fresh > COUNT_WIDTH'(cfg.min_pulses_per_interval);
  assign vol       = cust_inc - start_r;
  assign vol_big   = CMP_WIDTH'(vol) > CMP_WIDTH'(cfg.min_event_pulses);
  assign accum_sum = sat_add(accum_r, vol);
  assign daily_sum = sat_add(daily_r, vol);
  assign life_sum  = sat_add(life_r, vol);

  always_comb begin
    cust_nxt     = cust_inc;
    tech_nxt     = step_flags.pulse ? tech_r + COUNT_WIDTH'(1) : tech_r;
    last_chk_nxt = last_chk_r;
    start_nxt    = start_r;
    active_nxt   = active_r;
    led_nxt      = led_r | step_flags.pulse;
    closed_nxt   = 1'b0;
    counted_nxt  = 1'b0;
    ival_nxt     = ival_r;
    idle_nxt     = idle_r;
    accum_nxt    = accum_r;
    daily_nxt    = daily_r;
    life_nxt     = life_r;
    events_nxt   = events_r;
    hours_nxt    = hours_r;

    if (step_flags.ms_tick) begin
      ival_nxt = ival_inc;
      idle_nxt = idle_inc;
      if (check) begin
        ival_nxt     = 16'd0;
        last_chk_nxt = cust_inc;
        if (flow) begin
          if (!active_r) begin
            active_nxt = 1'b1;
            // event starts at the count seen by the previous check
            start_nxt  = last_chk_r;
            if (events_r < fepa_pkg::SAT16_MAX) begin
              events_nxt = events_r + 16'd1;
            end
          end
          idle_nxt = 24'd0;
        end else if (active_r && (idle_inc >= cfg.flow_timeout_ms)) begin
          if (vol_big) begin
            accum_nxt   = accum_sum;
            daily_nxt   = daily_sum;
            life_nxt    = life_sum;
            counted_nxt = 1'b1;
          end
          active_nxt = 1'b0;
          closed_nxt = 1'b1;
        end
        if (!active_nxt) begin
          led_nxt = 1'b0;
        end
      end
    end

    if (step_flags.hour_tick && (hours_r < fepa_pkg::SAT16_MAX)) begin
      hours_nxt = hours_r + 16'd1;
    end

    if (step_flags.daily_reset) begin
      daily_nxt    = '0;
      events_nxt   = 16'd0;
      hours_nxt    = 16'd0;
      cust_nxt     = '0;
      last_chk_nxt = '0;
    end

    if (step_flags.clear_accumulated) begin
      accum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cust_r     <= '0;
      tech_r     <= '0;
      last_chk_r <= '0;
      start_r    <= '0;
      active_r   <= 1'b0;
      led_r      <= 1'b0;
      closed_r   <= 1'b0;
      counted_r  <= 1'b0;
      ival_r     <= 16'd0;
      idle_r     <= 24'd0;
      accum_r    <= '0;
      daily_r    <= '0;
      life_r     <= '0;
      events_r   <= 16'd0;
      hours_r    <= 16'd0;
    end else if (step_en) begin
      cust_r     <= cust_nxt;
      tech_r     <= tech_nxt;
      last_chk_r <= last_chk_nxt;
      start_r    <= start_nxt;
      active_r   <= active_nxt;
      led_r      <= led_nxt;
      closed_r   <= closed_nxt;
      counted_r  <= counted_nxt;
      ival_r     <= ival_nxt;
      idle_r     <= idle_nxt;
      accum_r    <= accum_nxt;
      daily_r    <= daily_nxt;
      life_r     <= life_nxt;
      events_r   <= events_nxt;
      hours_r    <= hours_nxt;
    end
  end

  // state registers double as the result register
  assign res_flags.flow_active   = active_r;
  assign res_flags.led_on        = led_r;
  assign res_flags.event_closed  = closed_r;
  assign res_flags.event_counted = counted_r;
  assign cust_cnt       = cust_r;
  assign tech_cnt       = tech_r;
  assign accum_total    = accum_r;
  assign daily_total    = daily_r;
  assign lifetime_total = life_r;
  assign events_cnt     = events_r;
  assign hours_cnt      = hours_r;

endmodule

// ===== rtl/core/flow_event_pulse_accounting.sv =====
// A request held in the input register reaches out_* as it advances into the
// state/result register. Throughput: one request per cycle while out_ready stays high;
// two stages, the input and state/result registers, let one new request wait while a
// result waits. The whole update is one pass of the accounting logic between them.
// Reset (synchronous, rst_n low): all counters, timers and totals clear to zero,
// configuration returns to its defaults, both stages empty.
module flow_event_pulse_accounting #(
  parameter int COUNT_WIDTH = 32,
  parameter int TOTAL_WIDTH = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_pulse,
  input  logic                   in_ms_tick,
  input  logic                   in_daily_reset,
  input  logic                   in_hour_tick,
  input  logic                   in_clear_accumulated,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_flow_active,
  output logic                   out_led_on,
  output logic                   out_event_closed,
  output logic                   out_event_counted,
  output logic [COUNT_WIDTH-1:0] out_customer_pulses,
  output logic [COUNT_WIDTH-1:0] out_technical_pulses,
  output logic [TOTAL_WIDTH-1:0] out_accumulated_pulses,
  output logic [TOTAL_WIDTH-1:0] out_daily_pulses,
  output logic [TOTAL_WIDTH-1:0] out_lifetime_pulses,
  output logic [15:0]            out_flow_events_today,
  output logic [15:0]            out_hours_elapsed,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  fepa_pkg::in_flags_t  in_flags_r;
  fepa_pkg::in_flags_t  in_flags_nxt;
  logic                 in_vld_r, in_vld_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 advance;
  fepa_pkg::cfg_t       cfg_r, cfg_nxt;
  fepa_pkg::res_flags_t res_flags;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  assign in_flags_nxt.pulse             = in_pulse;
  assign in_flags_nxt.ms_tick           = in_ms_tick;
  assign in_flags_nxt.daily_reset       = in_daily_reset;
  assign in_flags_nxt.hour_tick         = in_hour_tick;
  assign in_flags_nxt.clear_accumulated = in_clear_accumulated;

  always_comb begin
    in_vld_nxt  = (in_vld_r && !advance) || (in_valid && in_ready);
    out_vld_nxt = advance || (out_vld_r && !out_ready);
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (fepa_pkg::cfg_idx_t'(cfg_index))
        fepa_pkg::CFG_CHECK_INTERVAL: cfg_nxt.check_interval_ms       = cfg_data[15:0];
        fepa_pkg::CFG_MIN_PULSES:     cfg_nxt.min_pulses_per_interval = cfg_data[15:0];
        fepa_pkg::CFG_FLOW_TIMEOUT:   cfg_nxt.flow_timeout_ms         = cfg_data[23:0];
        fepa_pkg::CFG_MIN_EVENT:      cfg_nxt.min_event_pulses        = cfg_data;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r                      <= 1'b0;
      out_vld_r                     <= 1'b0;
      cfg_r.check_interval_ms       <= fepa_pkg::CHECK_INTERVAL_RST;
      cfg_r.min_pulses_per_interval <= fepa_pkg::MIN_PULSES_RST;
      cfg_r.flow_timeout_ms         <= fepa_pkg::FLOW_TIMEOUT_RST;
      cfg_r.min_event_pulses        <= fepa_pkg::MIN_EVENT_RST;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      cfg_r     <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_flags_r <= in_flags_nxt;
    end
  end

  fepa_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (advance),
    .step_flags     (in_flags_r),
    .cfg            (cfg_r),
    .res_flags      (res_flags),
    .cust_cnt       (out_customer_pulses),
    .tech_cnt       (out_technical_pulses),
    .accum_total    (out_accumulated_pulses),
    .daily_total    (out_daily_pulses),
    .lifetime_total (out_lifetime_pulses),
    .events_cnt     (out_flow_events_today),
    .hours_cnt      (out_hours_elapsed)
  );

  assign out_valid         = out_vld_r;
  assign out_flow_active   = res_flags.flow_active;
  assign out_led_on        = res_flags.led_on;
  assign out_event_closed  = res_flags.event_closed;
  assign out_event_counted = res_flags.event_counted;

endmodule
